// File: rtl/rgbpb_pkg.sv
// shared types and constants of the rgb pixel blend unit
`timescale 1ns / 1ps

package rgbpb_pkg;

  // channel and arithmetic widths
  localparam int unsigned CH_W    = 8;
  localparam int unsigned PROD_W  = 2 * CH_W;
  localparam int unsigned NUM_W   = PROD_W + 2;
  localparam int unsigned QUO_W   = CH_W + 1;
  localparam int unsigned MODE_W  = 2;
  localparam int unsigned LANES   = 3;
  localparam int unsigned SUM_W   = CH_W + 2;

  // arithmetic constants
  localparam logic [CH_W-1:0]  CH_MAX     = 8'd255;
  localparam logic [NUM_W-1:0] RND_BIAS   = 18'd127;
  localparam logic [SUM_W-1:0] DARK_LIMIT = 10'd382;

  // blend mode codes
  localparam logic [MODE_W-1:0] MODE_MUL = 2'd0;
  localparam logic [MODE_W-1:0] MODE_SUB = 2'd1;
  localparam logic [MODE_W-1:0] MODE_SCR = 2'd2;
  localparam logic [MODE_W-1:0] MODE_OVL = 2'd3;

  // input word: top and bottom pixel
  typedef struct packed {
    logic [CH_W-1:0] top_blue;
    logic [CH_W-1:0] top_green;
    logic [CH_W-1:0] top_red;
    logic [CH_W-1:0] bottom_blue;
    logic [CH_W-1:0] bottom_green;
    logic [CH_W-1:0] bottom_red;
  } in_word_t;

  // result word: blended pixel
  typedef struct packed {
    logic [CH_W-1:0] out_blue;
    logic [CH_W-1:0] out_green;
    logic [CH_W-1:0] out_red;
  } out_word_t;

  // per-lane operation control
  typedef struct packed {
    logic sub;   // take the clipped difference
    logic inv;   // work on complements and invert the quotient
    logic dbl;   // double the product before rounding
  } lane_ctrl_t;

endpackage

// File: rtl/rgb_pixel_blend_unit.sv
// top level: mode register, dark test, three channel lanes, result merge
//
//   channel | ports                          | handshake
//   --------+--------------------------------+--------------------------------
//   input   | start, busy, in_pixel          | taken when start and not busy
//   result  | out_valid, out_pixel           | one-cycle strobe, no stall
//   config  | cfg_we, cfg_wdata              | blend mode written when cfg_we
//
// one pixel per clock; busy is never raised
// the result passes through the lane pipeline registers: product, quotient
// estimate, correction and clamp
// rst_n is synchronous and clears the valid pipeline and the blend mode
// the receiver cannot stall, a result is shown for exactly one cycle
`timescale 1ns / 1ps

module rgb_pixel_blend_unit (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  rgbpb_pkg::in_word_t           in_pixel,
  output logic                          out_valid,
  output rgbpb_pkg::out_word_t          out_pixel,
  input  logic                          cfg_we,
  input  logic [rgbpb_pkg::MODE_W-1:0]  cfg_wdata
);

  logic [rgbpb_pkg::MODE_W-1:0]  blend_mode_r;
  logic [rgbpb_pkg::MODE_W-1:0]  blend_mode_nxt;
  logic [2:0]                    vld_r;
  logic [2:0]                    vld_nxt;
  logic                          accept;
  logic [rgbpb_pkg::SUM_W-1:0]   bot_sum;
  logic                          dark;
  rgbpb_pkg::lane_ctrl_t         ctrl;
  logic [rgbpb_pkg::CH_W-1:0]    t_ch   [rgbpb_pkg::LANES];
  logic [rgbpb_pkg::CH_W-1:0]    b_ch   [rgbpb_pkg::LANES];
  logic [rgbpb_pkg::CH_W-1:0]    res_ch [rgbpb_pkg::LANES];

  assign busy   = 1'b0;
  assign accept = start & ~busy;

  // shared dark test on the bottom pixel, then mode decode
  always_comb begin
    bot_sum  = {2'b00, in_pixel.bottom_blue} + {2'b00, in_pixel.bottom_green}
             + {2'b00, in_pixel.bottom_red};
    dark     = (bot_sum <= rgbpb_pkg::DARK_LIMIT);
    ctrl.sub = (blend_mode_r == rgbpb_pkg::MODE_SUB);
    ctrl.inv = (blend_mode_r == rgbpb_pkg::MODE_SCR)
             | ((blend_mode_r == rgbpb_pkg::MODE_OVL) & ~dark);
    ctrl.dbl = (blend_mode_r == rgbpb_pkg::MODE_OVL);
  end

  // channel split
  assign t_ch[0] = in_pixel.top_blue;
  assign t_ch[1] = in_pixel.top_green;
  assign t_ch[2] = in_pixel.top_red;
  assign b_ch[0] = in_pixel.bottom_blue;
  assign b_ch[1] = in_pixel.bottom_green;
  assign b_ch[2] = in_pixel.bottom_red;

  // one lane per channel
  for (genvar i = 0; i < rgbpb_pkg::LANES; i++) begin : g_lane
    rgbpb_lane u_lane (
      .clk    (clk),
      .t_i    (t_ch[i]),
      .b_i    (b_ch[i]),
      .ctrl_i (ctrl),
      .res_o  (res_ch[i])
    );
  end

  // mode register and valid pipeline
  always_comb begin
    blend_mode_nxt = cfg_we ? cfg_wdata : blend_mode_r;
    vld_nxt        = {vld_r[1:0], accept};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      blend_mode_r <= rgbpb_pkg::MODE_MUL;
      vld_r        <= '0;
    end else begin
      blend_mode_r <= blend_mode_nxt;
      vld_r        <= vld_nxt;
    end
  end

  // merge lane results into the result word
  assign out_valid          = vld_r[2];
  assign out_pixel.out_blue  = res_ch[0];
  assign out_pixel.out_green = res_ch[1];
  assign out_pixel.out_red   = res_ch[2];

  // every result strobe traces back to an earlier taken input word
  a_out_from_start: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(accept, 3))
    else $error("result strobe without a matching input word");

  // every word taken out of reset gives a result strobe
  a_start_to_out: assert property (@(posedge clk) disable iff (!rst_n)
    ($past(accept, 3) && $past(rst_n, 3) && $past(rst_n, 2) && $past(rst_n, 1))
      |-> out_valid)
    else $error("input word lost in the pipeline");

  // multiply by a black top channel gives black
  a_mul_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && $past(blend_mode_r == rgbpb_pkg::MODE_MUL, 3)
      && $past(in_pixel.top_red == 8'd0, 3) && $past(cfg_we, 2) == 1'b0
      && $past(cfg_we, 1) == 1'b0)
      |-> (out_pixel.out_red == 8'd0))
    else $error("multiply of zero top channel is not zero");

  // screen with a white top channel gives white
  a_scr_white: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && $past(blend_mode_r == rgbpb_pkg::MODE_SCR, 3)
      && $past(in_pixel.top_green == rgbpb_pkg::CH_MAX, 3))
      |-> (out_pixel.out_green == rgbpb_pkg::CH_MAX))
    else $error("screen of white top channel is not white");

endmodule

// File: rtl/rgbpb_lane.sv
// one channel lane: product, divide by 255 with rounding, clamp or invert, or clipped difference
`timescale 1ns / 1ps

module rgbpb_lane (
  input  logic                         clk,
  input  logic [rgbpb_pkg::CH_W-1:0]   t_i,
  input  logic [rgbpb_pkg::CH_W-1:0]   b_i,
  input  rgbpb_pkg::lane_ctrl_t        ctrl_i,
  output logic [rgbpb_pkg::CH_W-1:0]   res_o
);

  logic [rgbpb_pkg::CH_W-1:0]    op_a;
  logic [rgbpb_pkg::CH_W-1:0]    op_c;
  logic [rgbpb_pkg::PROD_W-1:0]  prod;
  logic [rgbpb_pkg::NUM_W-1:0]   y1_nxt;
  logic [rgbpb_pkg::CH_W-1:0]    sub1_nxt;
  logic [rgbpb_pkg::NUM_W-1:0]   y1_r;
  logic [rgbpb_pkg::CH_W-1:0]    sub1_r;
  rgbpb_pkg::lane_ctrl_t         ctrl1_r;

  logic [rgbpb_pkg::NUM_W+8:0]   est_full;
  logic [rgbpb_pkg::QUO_W-1:0]   qe2_r;
  logic [rgbpb_pkg::NUM_W-1:0]   y2_r;
  logic [rgbpb_pkg::CH_W-1:0]    sub2_r;
  rgbpb_pkg::lane_ctrl_t         ctrl2_r;

  logic [rgbpb_pkg::QUO_W+7:0]   qx255;
  logic [rgbpb_pkg::NUM_W-1:0]   rem;
  logic [rgbpb_pkg::QUO_W-1:0]   q;
  logic [rgbpb_pkg::CH_W-1:0]    res_nxt;
  logic [rgbpb_pkg::CH_W-1:0]    res_r;

  // stage 1: operands, product, rounding bias, clipped difference
  always_comb begin
    op_a     = ctrl_i.inv ? ~t_i : t_i;
    op_c     = ctrl_i.inv ? ~b_i : b_i;
    prod     = op_a * op_c;
    y1_nxt   = (ctrl_i.dbl ? {1'b0, prod, 1'b0} : {2'b00, prod}) + rgbpb_pkg::RND_BIAS;
    sub1_nxt = (b_i > t_i) ? (b_i - t_i) : '0;
  end

  // stage 2: quotient estimate, y * 257 / 2^16 (never above the true quotient)
  assign est_full = {9'd0, y1_r} + {1'b0, y1_r, 8'd0};

  // stage 3: one correction step, then clamp, invert or pass the clipped difference
  always_comb begin
    qx255 = {qe2_r, 8'd0} - {8'd0, qe2_r};
    rem   = y2_r - {1'b0, qx255};
    q     = qe2_r + {8'd0, (rem >= 18'd255)};
    if (ctrl2_r.sub) begin
      res_nxt = sub2_r;
    end else if (ctrl2_r.inv) begin
      res_nxt = q[rgbpb_pkg::CH_W] ? '0 : ~q[rgbpb_pkg::CH_W-1:0];
    end else begin
      res_nxt = q[rgbpb_pkg::CH_W] ? rgbpb_pkg::CH_MAX : q[rgbpb_pkg::CH_W-1:0];
    end
  end

  // lane pipeline registers
  always_ff @(posedge clk) begin
    y1_r    <= y1_nxt;
    sub1_r  <= sub1_nxt;
    ctrl1_r <= ctrl_i;
    qe2_r   <= est_full[24:16];
    y2_r    <= y1_r;
    sub2_r  <= sub1_r;
    ctrl2_r <= ctrl1_r;
    res_r   <= res_nxt;
  end

  assign res_o = res_r;

endmodule
